FILE: design/wsfz_pkg.sv
// Package for the wheel speed frame decoder with zero debounce.
// Holds frame signature constants, register codes, reset values and the queue entry type.
// No dependencies.
`timescale 1ns / 1ps

package wsfz_pkg;

    // Speed frame signature: data bytes 1..3 and the required length
    localparam logic [7:0] SIG_BYTE1       = 8'h6C;
    localparam logic [7:0] SIG_BYTE2       = 8'h60;
    localparam logic [7:0] SIG_BYTE3       = 8'h03;
    localparam logic [3:0] SPEED_FRAME_LEN = 4'd8;

    // Zero run counter stops here
    localparam logic [3:0] ZERO_RUN_MAX = 4'd15;

    // Register indexes
    localparam logic [1:0] REG_FRONT_ID = 2'd0;
    localparam logic [1:0] REG_REAR_ID  = 2'd1;
    localparam logic [1:0] REG_ZERO_THR = 2'd2;
    localparam logic [1:0] REG_CONFIRM  = 2'd3;

    // Register reset values
    localparam logic [10:0] FRONT_ID_RST = 11'h581;
    localparam logic [10:0] REAR_ID_RST  = 11'h582;
    localparam logic [15:0] ZERO_THR_RST = 16'd10;
    localparam logic [3:0]  CONFIRM_RST  = 4'd3;

    // One classified frame, passed from front to back
    typedef struct packed {
        logic        taken;      // valid speed frame for either drive
        logic        is_front;   // front drive wins when both ids match
        logic        near_zero;  // both magnitudes below threshold
        logic [15:0] left;
        logic [15:0] right;
    } t_cmd;

    // Magnitude of a 16-bit two's complement value; -32768 gives 32768
    function automatic logic [16:0] magnitude16(input logic [15:0] raw);
        logic [16:0] mag;
        if (raw[15]) begin
            mag = 17'h10000 - {1'b0, raw};
        end else begin
            mag = {1'b0, raw};
        end
        return mag;
    endfunction

endpackage

FILE: design/wsfz_channels.sv
// Handshake channel interfaces: frame input, speed result output, register writes.
// Depends on nothing.
`timescale 1ns / 1ps

interface wsfz_frame_if;
    logic        valid;
    logic        ready;
    logic [10:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] payload;

    modport source (output valid, frame_id, frame_length, payload, input ready);
    modport sink   (input valid, frame_id, frame_length, payload, output ready);
endinterface

interface wsfz_speed_if;
    logic               valid;
    logic               ready;
    logic               frame_taken;
    logic signed [15:0] front_left_speed;
    logic signed [15:0] front_right_speed;
    logic signed [15:0] rear_left_speed;
    logic signed [15:0] rear_right_speed;

    modport source (output valid, frame_taken, front_left_speed, front_right_speed,
                    rear_left_speed, rear_right_speed, input ready);
    modport sink   (input valid, frame_taken, front_left_speed, front_right_speed,
                    rear_left_speed, rear_right_speed, output ready);
endinterface

interface wsfz_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [15:0] data;

    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

FILE: design/wsfz_fifo.sv
// Small register FIFO between the classifier and the state update.
// No package dependency.
`timescale 1ns / 1ps

module wsfz_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2   // 2 or more
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    // Pointer wrap and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(w_push) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: design/wsfz_front.sv
// Front end: register file and frame classification (id, length, signature, near-zero test).
// Depends on wsfz_pkg and the channel interfaces.
`timescale 1ns / 1ps

module wsfz_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wsfz_frame_if.sink        i_frame,
    wsfz_cfg_if.sink          i_cfg,
    input  logic              i_full,
    output logic              o_push,
    output wsfz_pkg::t_cmd    o_cmd,
    output logic [3:0]        o_confirm
);

    logic [10:0] r_front_id;
    logic [10:0] r_rear_id;
    logic [15:0] r_zero_thr;
    logic [3:0]  r_confirm;

    logic        w_is_front, w_is_rear, w_shape_ok;
    logic [15:0] w_left, w_right;
    logic [16:0] w_thr;

    // Register writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_id <= wsfz_pkg::FRONT_ID_RST;
            r_rear_id  <= wsfz_pkg::REAR_ID_RST;
            r_zero_thr <= wsfz_pkg::ZERO_THR_RST;
            r_confirm  <= wsfz_pkg::CONFIRM_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                wsfz_pkg::REG_FRONT_ID: r_front_id <= i_cfg.data[10:0];
                wsfz_pkg::REG_REAR_ID:  r_rear_id  <= i_cfg.data[10:0];
                wsfz_pkg::REG_ZERO_THR: r_zero_thr <= i_cfg.data;
                wsfz_pkg::REG_CONFIRM:  r_confirm  <= i_cfg.data[3:0];
                default: ;
            endcase
        end
    end

    assign o_confirm = r_confirm;

    // Classify the frame on the input beat
    assign w_is_front = (i_frame.frame_id == r_front_id);
    assign w_is_rear  = (i_frame.frame_id == r_rear_id);
    assign w_shape_ok = (i_frame.frame_length == wsfz_pkg::SPEED_FRAME_LEN)
                     && (i_frame.payload[15:8]  == wsfz_pkg::SIG_BYTE1)
                     && (i_frame.payload[23:16] == wsfz_pkg::SIG_BYTE2)
                     && (i_frame.payload[31:24] == wsfz_pkg::SIG_BYTE3);
    assign w_left     = i_frame.payload[47:32];
    assign w_right    = i_frame.payload[63:48];
    assign w_thr      = {1'b0, r_zero_thr};

    always_comb begin
        o_cmd.taken     = w_shape_ok && (w_is_front || w_is_rear);
        o_cmd.is_front  = w_is_front;
        o_cmd.near_zero = (wsfz_pkg::magnitude16(w_left) < w_thr)
                       && (wsfz_pkg::magnitude16(w_right) < w_thr);
        o_cmd.left      = w_left;
        o_cmd.right     = w_right;
    end

    assign i_frame.ready = !i_full;
    assign o_push        = i_frame.valid && !i_full;

endmodule

FILE: design/wsfz_back.sv
// Back end: per-drive speed store, zero run counters and the result register.
// Depends on wsfz_pkg and the channel interfaces.
`timescale 1ns / 1ps

module wsfz_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  wsfz_pkg::t_cmd  i_cmd,
    input  logic [3:0]      i_confirm,
    output logic            o_pop,
    wsfz_speed_if.source    o_speed
);

    logic [31:0] r_front_speeds, n_front_speeds;
    logic [31:0] r_rear_speeds,  n_rear_speeds;
    logic [3:0]  r_front_run,    n_front_run;
    logic [3:0]  r_rear_run,     n_rear_run;
    logic        r_valid;
    logic        r_taken;
    logic [3:0]  w_run_sel, w_run_inc;
    logic [31:0] w_new_speeds;

    // Take the next entry when the result register is free or draining
    assign o_pop = !i_empty && (!r_valid || o_speed.ready);

    // Debounce step on the addressed drive
    always_comb begin
        w_run_sel    = i_cmd.is_front ? r_front_run : r_rear_run;
        w_run_inc    = (w_run_sel < wsfz_pkg::ZERO_RUN_MAX) ? w_run_sel + 1'b1 : w_run_sel;
        w_new_speeds = i_cmd.is_front ? r_front_speeds : r_rear_speeds;
        if (i_cmd.near_zero) begin
            if (w_run_inc >= i_confirm) begin
                w_new_speeds = '0;
            end
        end else begin
            w_run_inc    = '0;
            w_new_speeds = {i_cmd.right, i_cmd.left};
        end

        n_front_speeds = r_front_speeds;
        n_rear_speeds  = r_rear_speeds;
        n_front_run    = r_front_run;
        n_rear_run     = r_rear_run;
        if (o_pop && i_cmd.taken) begin
            if (i_cmd.is_front) begin
                n_front_speeds = w_new_speeds;
                n_front_run    = w_run_inc;
            end else begin
                n_rear_speeds = w_new_speeds;
                n_rear_run    = w_run_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_speeds <= '0;
            r_rear_speeds  <= '0;
            r_front_run    <= '0;
            r_rear_run     <= '0;
            r_valid        <= 1'b0;
        end else begin
            r_front_speeds <= n_front_speeds;
            r_rear_speeds  <= n_rear_speeds;
            r_front_run    <= n_front_run;
            r_rear_run     <= n_rear_run;
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (o_speed.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_taken <= i_cmd.taken;
        end
    end

    // The stored speeds are the result payload; they change only on a pop
    assign o_speed.valid             = r_valid;
    assign o_speed.frame_taken       = r_taken;
    assign o_speed.front_left_speed  = r_front_speeds[15:0];
    assign o_speed.front_right_speed = r_front_speeds[31:16];
    assign o_speed.rear_left_speed   = r_rear_speeds[15:0];
    assign o_speed.rear_right_speed  = r_rear_speeds[31:16];

endmodule

FILE: design/wheel_speed_frame_zero_debounce_unit.sv
// Wheel speed frame decoder with zero-speed debounce, top level.
// Path: an accepted frame is registered into the queue and then into the result register,
// and a stalled result beat holds later frames in the queue.
// Throughput: one frame per cycle while the result output is not stalled.
// The queue lets the input keep flowing for QUEUE_DEPTH beats while the output stalls.
// Reset (synchronous, active low) restores register defaults, clears stored speeds,
// zero run counters, the queue and the result register.
`timescale 1ns / 1ps

module wheel_speed_frame_zero_debounce_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wsfz_frame_if.sink   i_frame,
    wsfz_cfg_if.sink     i_cfg,
    wsfz_speed_if.source o_speed
);

    wsfz_pkg::t_cmd w_push_cmd;
    wsfz_pkg::t_cmd w_pop_cmd;
    logic           w_push, w_full, w_pop, w_empty;
    logic [3:0]     w_confirm;

    wsfz_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_frame   (i_frame),
        .i_cfg     (i_cfg),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd),
        .o_confirm (w_confirm)
    );

    wsfz_fifo #(
        .WIDTH ($bits(wsfz_pkg::t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_cmd),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_cmd),
        .o_empty     (w_empty)
    );

    wsfz_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (w_empty),
        .i_cmd     (w_pop_cmd),
        .i_confirm (w_confirm),
        .o_pop     (w_pop),
        .o_speed   (o_speed)
    );

endmodule

FILE: design/wsfz_checker.sv
// Port-level checks for the wheel speed decoder, attached to the top level by bind.
// Depends on the top level's ports only.
`timescale 1ns / 1ps

module wsfz_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_taken,
    input logic [63:0] i_out_speeds,
    input logic        i_cfg_ready
);

    // Output register is empty right after reset
    a_out_idle_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // A fresh result matches an earlier accepted input beat, passed on through the queue and result register
    a_result_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(i_out_valid) && $past(i_rst_n, 2)) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without a matching input beat");

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_taken)
                                           && $stable(i_out_speeds)))
        else $error("stalled result beat changed");

    // Register writes never stall outside reset
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("register write port stalled");

endmodule

bind wheel_speed_frame_zero_debounce_unit wsfz_checker u_wsfz_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_frame.valid),
    .i_in_ready   (i_frame.ready),
    .i_out_valid  (o_speed.valid),
    .i_out_ready  (o_speed.ready),
    .i_out_taken  (o_speed.frame_taken),
    .i_out_speeds ({o_speed.front_left_speed, o_speed.front_right_speed,
                    o_speed.rear_left_speed, o_speed.rear_right_speed}),
    .i_cfg_ready  (i_cfg.ready)
);
